### hdl/bic_pkg.sv
package bic_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int THRESH_BITS = 16;
    localparam int SUM_BITS    = 17;
    localparam int STATE_BITS  = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};

    localparam logic [STATE_BITS-1:0] SECTOR_FIRST = 3'd1;
    localparam logic [STATE_BITS-1:0] SECTOR_LAST  = 3'd6;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [STATE_BITS-1:0]  sector_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    typedef enum logic
    {
        KIND_PWM    = 1'b0,
        KIND_PRESET = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0]
    {
        REG_BLANK_TIME  = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_REVERSE_DIR = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_idx_t;

    function automatic sector_t next_sector(input sector_t s, input logic reverse);
        sector_t n;
        if (reverse)
        begin
            n = (s <= SECTOR_FIRST) ? SECTOR_LAST : sector_t'(s - 3'd1);
        end
        else
        begin
            n = (s >= SECTOR_LAST) ? SECTOR_FIRST : sector_t'(s + 3'd1);
        end
        return n;
    endfunction

endpackage

### hdl/bic_if.sv
interface bic_in_if;
    import bic_pkg::*;

    logic    valid;
    logic    ready;
    kind_t   kind;
    sample_t bemf_sample;
    sample_t center_level;
    sector_t preset_state;

    modport source (output valid, kind, bemf_sample, center_level, preset_state, input ready);
    modport sink   (input valid, kind, bemf_sample, center_level, preset_state, output ready);
endinterface

interface bic_out_if;
    import bic_pkg::*;

    logic    valid;
    logic    ready;
    logic    commutate;
    sector_t comm_state;
    sum_t    integrated_sum;

    modport source (output valid, commutate, comm_state, integrated_sum, input ready);
    modport sink   (input valid, commutate, comm_state, integrated_sum, output ready);
endinterface

interface bic_cfg_if;
    import bic_pkg::*;

    logic                     valid;
    logic                     ready;
    cfg_idx_t                 index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/bemf_integration_commutator.sv
// Channel  Role    Payload
// cfg      sink    index, data (register write)
// item     sink    kind, bemf_sample, center_level, preset_state
// result   source  commutate, comm_state, integrated_sum
//
// One item per clock while result.ready is high; each accepted item gives one result item in the next cycle.
// The result is registered after the integrate/compare path.
// item.ready is low only while a result is held and result.ready is low.
// Reset clears the blank counter and sum, sets the sector to 1 and the registers to 0.
// cfg is always ready.
module bemf_integration_commutator
(
    input  logic             clk,
    input  logic             rst_n,
    bic_cfg_if.sink          cfg,
    bic_in_if.sink           item,
    bic_out_if.source        result
);
    import bic_pkg::*;

    logic [COUNT_BITS-1:0]  blank_time_reg;
    logic [THRESH_BITS-1:0] threshold_reg;
    logic                   reverse_reg;

    count_t  blank_count_reg, blank_count_next;
    sum_t    bemf_sum_reg, bemf_sum_next;
    sector_t comm_state_reg, comm_state_next;

    logic    out_valid_reg;
    logic    commutate_reg, commutate_next;
    sector_t out_state_reg;
    sum_t    out_sum_reg;

    logic                   accept;
    count_t                 count_inc;
    logic                   falling;
    sample_t                add;
    logic [SUM_BITS:0]      sum_wide;
    sum_t                   sum_sat;

    assign cfg.ready  = 1'b1;
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    assign result.valid          = out_valid_reg;
    assign result.commutate      = commutate_reg;
    assign result.comm_state     = out_state_reg;
    assign result.integrated_sum = out_sum_reg;

    always_comb
    begin
        count_inc = (blank_count_reg != COUNT_MAX) ? count_t'(blank_count_reg + 1'b1)
                                                   : blank_count_reg;
        falling   = comm_state_reg[0] ^ reverse_reg;
        add       = '0;
        if (falling)
        begin
            if (item.bemf_sample <= item.center_level)
            begin
                add = sample_t'(item.center_level - item.bemf_sample);
            end
        end
        else
        begin
            if (item.bemf_sample >= item.center_level)
            begin
                add = sample_t'(item.bemf_sample - item.center_level);
            end
        end
        sum_wide = {1'b0, bemf_sum_reg} + {{(SUM_BITS + 1 - SAMPLE_BITS){1'b0}}, add};
        sum_sat  = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

        blank_count_next = blank_count_reg;
        bemf_sum_next    = bemf_sum_reg;
        comm_state_next  = comm_state_reg;
        commutate_next   = 1'b0;

        case (item.kind)
            KIND_PRESET:
            begin
                if (item.preset_state inside {[SECTOR_FIRST:SECTOR_LAST]})
                begin
                    comm_state_next = item.preset_state;
                end
            end
            default:
            begin
                blank_count_next = count_inc;
                if (count_inc > blank_time_reg)
                begin
                    bemf_sum_next = sum_sat;
                    if (sum_sat >= {1'b0, threshold_reg})
                    begin
                        bemf_sum_next    = '0;
                        blank_count_next = '0;
                        comm_state_next  = next_sector(comm_state_reg, reverse_reg);
                        commutate_next   = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_time_reg <= '0;
            threshold_reg  <= '0;
            reverse_reg    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BLANK_TIME:  blank_time_reg <= cfg.data[COUNT_BITS-1:0];
                REG_THRESHOLD:   threshold_reg  <= cfg.data[THRESH_BITS-1:0];
                REG_REVERSE_DIR: reverse_reg    <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_count_reg <= '0;
            bemf_sum_reg    <= '0;
            comm_state_reg  <= SECTOR_FIRST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                blank_count_reg <= blank_count_next;
                bemf_sum_reg    <= bemf_sum_next;
                comm_state_reg  <= comm_state_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            commutate_reg <= commutate_next;
            out_state_reg <= comm_state_next;
            out_sum_reg   <= bemf_sum_next;
        end
    end

endmodule
